### design/ofbe_pkg.sv
// shared types and constants for the oldest-first budget eviction unit
`default_nettype none

package ofbe_pkg;

  localparam int AGE_W     = 63;
  localparam int IN_SIZE_W = 40;
  localparam int TOTAL_W   = 46;
  localparam int BUDGET_W  = 48;
  localparam int VIDX_W    = 6;
  // wide enough for a 46-bit total plus a size of up to 48 bits
  localparam int CALC_W    = 49;

  localparam logic [CALC_W-1:0] TOTAL_MAX = CALC_W'((64'd1 << TOTAL_W) - 64'd1);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_CHECK,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // sequencer commands to the datapath
  typedef struct packed {
    logic in_ready;
    logic emit_none;
    logic emit_victim;
    logic scan_start;
    logic scan_first;
    logic clear;
  } ofbe_ctl_t;

  // datapath status back to the sequencer
  typedef struct packed {
    logic in_fire;
    logic in_last;
    logic over_budget;
    logic scan_done;
    logic out_free;
    logic more;
  } ofbe_sts_t;

endpackage

`default_nettype wire

### design/ofbe_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module ofbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### design/ofbe_scan.sv
// one pass over the entry table: finds the oldest entry not yet evicted
`default_nettype none

module ofbe_scan import ofbe_pkg::*; #(
  parameter int MAX_ENTRIES = 64,
  parameter int SIZE_BITS   = 40
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic                             first,
  input  wire logic [$clog2(MAX_ENTRIES):0]     count,
  output logic                                  rd_en,
  output logic      [$clog2(MAX_ENTRIES)-1:0]   rd_addr,
  input  wire logic [AGE_W+SIZE_BITS-1:0]       rd_data,
  output logic                                  done,
  output logic      [$clog2(MAX_ENTRIES)-1:0]   best_idx,
  output logic      [SIZE_BITS-1:0]             best_size
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = IDX_W + 1;

  logic             active_r, active_nxt;
  logic [CNT_W-1:0] iss_r, iss_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] pidx_r, pidx_nxt;
  logic             found_r, found_nxt;
  logic [AGE_W-1:0] best_age_r, best_age_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic [SIZE_BITS-1:0] best_size_r, best_size_nxt;
  logic             have_prev_r, have_prev_nxt;
  logic [AGE_W-1:0] prev_age_r, prev_age_nxt;
  logic [IDX_W-1:0] prev_idx_r, prev_idx_nxt;

  logic [AGE_W-1:0]     cand_age;
  logic [SIZE_BITS-1:0] cand_size;
  logic                 cand_ok;
  logic                 take;
  logic                 last_rd;

  assign cand_age  = rd_data[AGE_W+SIZE_BITS-1:SIZE_BITS];
  assign cand_size = rd_data[SIZE_BITS-1:0];

  assign rd_en   = active_r && (iss_r < count);
  assign rd_addr = iss_r[IDX_W-1:0];

  // candidate must come strictly after the previous victim in (age, load order)
  assign cand_ok = !have_prev_r || (cand_age > prev_age_r) ||
                   ((cand_age == prev_age_r) && (pidx_r > prev_idx_r));
  // ascending index order makes a strict age compare keep load order on ties
  assign take    = pend_r && cand_ok && (!found_r || (cand_age < best_age_r));
  assign last_rd = pend_r && ({1'b0, pidx_r} == (count - CNT_W'(1)));

  assign done      = last_rd;
  assign best_idx  = best_idx_r;
  assign best_size = best_size_r;

  always_comb begin
    active_nxt    = active_r;
    iss_nxt       = iss_r;
    pend_nxt      = rd_en;
    pidx_nxt      = iss_r[IDX_W-1:0];
    found_nxt     = found_r;
    best_age_nxt  = best_age_r;
    best_idx_nxt  = best_idx_r;
    best_size_nxt = best_size_r;
    have_prev_nxt = have_prev_r;
    prev_age_nxt  = prev_age_r;
    prev_idx_nxt  = prev_idx_r;
    if (rd_en) begin
      iss_nxt = iss_r + CNT_W'(1);
    end
    if (take) begin
      found_nxt     = 1'b1;
      best_age_nxt  = cand_age;
      best_idx_nxt  = pidx_r;
      best_size_nxt = cand_size;
    end
    if (last_rd) begin
      active_nxt = 1'b0;
    end
    if (start) begin
      active_nxt    = 1'b1;
      iss_nxt       = '0;
      pend_nxt      = 1'b0;
      found_nxt     = 1'b0;
      have_prev_nxt = !first;
      // last victim becomes the lower bound for the next pass
      prev_age_nxt  = best_age_r;
      prev_idx_nxt  = best_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      have_prev_r <= 1'b0;
      iss_r       <= '0;
    end else begin
      active_r    <= active_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      have_prev_r <= have_prev_nxt;
      iss_r       <= iss_nxt;
    end
    pidx_r      <= pidx_nxt;
    best_age_r  <= best_age_nxt;
    best_idx_r  <= best_idx_nxt;
    best_size_r <= best_size_nxt;
    prev_age_r  <= prev_age_nxt;
    prev_idx_r  <= prev_idx_nxt;
  end

endmodule

`default_nettype wire

### design/ofbe_ctrl.sv
// sequencer: load, budget check, scan passes and result hand-off
`default_nettype none

module ofbe_ctrl import ofbe_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire ofbe_sts_t sts,
  output ofbe_ctl_t      ctl
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (sts.in_fire && sts.in_last) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.over_budget) begin
          state_nxt = ST_SCAN;
        end else if (sts.out_free) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          state_nxt = sts.more ? ST_SCAN : ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state_r)
      ST_LOAD: begin
        ctl.in_ready = 1'b1;
      end
      ST_CHECK: begin
        if (sts.over_budget) begin
          ctl.scan_start = 1'b1;
          ctl.scan_first = 1'b1;
        end else if (sts.out_free) begin
          ctl.emit_none = 1'b1;
          ctl.clear     = 1'b1;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          ctl.emit_victim = 1'b1;
          ctl.scan_start  = sts.more;
          ctl.clear       = !sts.more;
        end
      end
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### design/oldest_first_budget_eviction_unit.sv
// top level: oldest-first eviction of a loaded entry batch against a byte budget
//
//   port group | direction | carries
//   in_        | in        | one entry request: age, size, last-of-batch mark
//   out_       | out       | one eviction result per victim, or one no-victim result
//   cfg_       | in        | byte budget register write
//
// entries load one per cycle while no pass is running (in_stall low in load state)
// after the last entry: a budget check, then per victim a full scan pass over the
// loaded entries, made of the sequential table read and compare
// a stalled output holds the sequencer at the result hand-off; the last result may
// still wait in the output register while the next batch loads
// synchronous reset clears control state only; the table needs no clearing pass
`default_nettype none

module oldest_first_budget_eviction_unit import ofbe_pkg::*; #(
  parameter int MAX_ENTRIES = 64,
  parameter int SIZE_BITS   = 40
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [AGE_W-1:0]     in_entry_age,
  input  wire logic [IN_SIZE_W-1:0] in_entry_size,
  input  wire logic                 in_batch_last,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [VIDX_W-1:0]    out_victim_index,
  output logic                      out_victim_valid,
  output logic      [TOTAL_W-1:0]   out_remaining_total,
  output logic                      out_table_overflow,
  output logic                      out_result_last,
  input  wire logic                 cfg_wr_en,
  input  wire logic [BUDGET_W-1:0]  cfg_wr_data
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = IDX_W + 1;
  localparam int ROW_W = AGE_W + SIZE_BITS;

  ofbe_ctl_t ctl;
  ofbe_sts_t sts;

  logic [BUDGET_W-1:0] budget_r;
  logic [TOTAL_W-1:0]  total_r, total_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    done_r, done_nxt;
  logic                ovf_r, ovf_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [VIDX_W-1:0]   out_victim_index_r;
  logic                out_victim_valid_r;
  logic [TOTAL_W-1:0]  out_remaining_total_r;
  logic                out_table_overflow_r;
  logic                out_result_last_r;

  logic                   in_fire;
  logic                   table_full;
  logic [SIZE_BITS+IN_SIZE_W-1:0] size_ext;
  logic [SIZE_BITS-1:0]   in_size;
  logic [CALC_W-1:0]      sum;
  logic [TOTAL_W-1:0]     sum_sat;
  logic [CALC_W-1:0]      diff;
  logic [TOTAL_W-1:0]     left_total;
  logic [CNT_W-1:0]       done_inc;

  logic                   wr_en;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic [ROW_W-1:0]       rd_data;
  logic                   scan_done;
  logic [IDX_W-1:0]       best_idx;
  logic [SIZE_BITS-1:0]   best_size;
  logic [IDX_W+VIDX_W-1:0] vidx_ext;

  assign in_stall = !ctl.in_ready;
  assign in_fire  = in_valid && ctl.in_ready;

  // entry size fitted to the table width
  assign size_ext = {{SIZE_BITS{1'b0}}, in_entry_size};
  assign in_size  = size_ext[SIZE_BITS-1:0];

  assign table_full = (count_r == CNT_W'(MAX_ENTRIES));
  assign wr_en      = in_fire && !table_full;

  // saturating add on load
  assign sum     = CALC_W'(total_r) + CALC_W'(in_size);
  assign sum_sat = (sum > TOTAL_MAX) ? TOTAL_MAX[TOTAL_W-1:0] : sum[TOTAL_W-1:0];

  // clamped subtract on eviction
  assign diff       = CALC_W'(total_r) - CALC_W'(best_size);
  assign left_total = diff[CALC_W-1] ? '0 : diff[TOTAL_W-1:0];

  assign done_inc = done_r + CNT_W'(1);
  assign vidx_ext = {{VIDX_W{1'b0}}, best_idx};

  ofbe_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data ({in_entry_age, in_size}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ofbe_scan #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .SIZE_BITS   (SIZE_BITS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (ctl.scan_start),
    .first     (ctl.scan_first),
    .count     (count_r),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .done      (scan_done),
    .best_idx  (best_idx),
    .best_size (best_size)
  );

  always_comb begin
    sts.in_fire     = in_fire;
    sts.in_last     = in_batch_last;
    sts.over_budget = ({2'b00, total_r} > budget_r);
    sts.scan_done   = scan_done;
    sts.out_free    = !out_valid_r || !out_stall;
    sts.more        = ({2'b00, left_total} > budget_r) && (done_inc < count_r);
  end

  ofbe_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .ctl   (ctl)
  );

  always_comb begin
    total_nxt = total_r;
    count_nxt = count_r;
    done_nxt  = done_r;
    ovf_nxt   = ovf_r;
    if (in_fire) begin
      if (table_full) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CNT_W'(1);
        total_nxt = sum_sat;
      end
    end
    if (ctl.emit_victim) begin
      total_nxt = left_total;
      done_nxt  = done_inc;
    end
    if (ctl.clear) begin
      total_nxt = '0;
      count_nxt = '0;
      done_nxt  = '0;
      ovf_nxt   = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (ctl.emit_none || ctl.emit_victim) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r    <= '0;
      total_r     <= '0;
      count_r     <= '0;
      done_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        budget_r <= cfg_wr_data;
      end
      total_r     <= total_nxt;
      count_r     <= count_nxt;
      done_r      <= done_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_none) begin
      out_victim_index_r    <= '0;
      out_victim_valid_r    <= 1'b0;
      out_remaining_total_r <= total_r;
      out_table_overflow_r  <= ovf_r;
      out_result_last_r     <= 1'b1;
    end else if (ctl.emit_victim) begin
      out_victim_index_r    <= vidx_ext[VIDX_W-1:0];
      out_victim_valid_r    <= 1'b1;
      out_remaining_total_r <= left_total;
      out_table_overflow_r  <= ovf_r;
      out_result_last_r     <= !sts.more;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_victim_index    = out_victim_index_r;
  assign out_victim_valid    = out_victim_valid_r;
  assign out_remaining_total = out_remaining_total_r;
  assign out_table_overflow  = out_table_overflow_r;
  assign out_result_last     = out_result_last_r;

endmodule

`default_nettype wire
